@@ rtl/kup_pkg.sv @@
package kup_pkg;

    localparam int OUT_BITS  = 22;

    typedef enum logic [1:0] {
        OP_LOAD_KERNEL = 2'd0,
        OP_LOAD_SAMPLE = 2'd1,
        OP_QUERY       = 2'd2,
        OP_NONE        = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_FACTOR = 2'd2,
        REG_ORDER  = 2'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SETUP,
        ST_READ,
        ST_MUL,
        ST_ACC,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]         operation;
        logic [5:0]         kern_col;
        logic [5:0]         kern_row;
        logic [5:0]         coarse_col;
        logic [5:0]         coarse_row;
        logic [8:0]         fine_col;
        logic [8:0]         fine_row;
        logic signed [15:0] load_value;
    } in_item_t;

    typedef struct packed {
        logic signed [21:0] interpolated_value;
        logic               range_error;
    } out_item_t;

endpackage

@@ rtl/kernel_upsample_2d.sv @@
// Channel  Direction  Handshake         Payload
// in       input      in_valid/ready    kup_pkg::in_item_t
// out      output     out_valid/ready   kup_pkg::out_item_t (output register)
// cfg      input      APB psel/penable  4 registers at 4*i
//
// A load is written at its accept and leaves the input open. A query keeps the input
// closed from its accept through the restoring divider per axis (fine / factor),
// a setup step, a read, multiply and accumulate step for each of (2*half_order)^2
// nodes (one multiplier, one adder) and a hand-off to the output register.
// Out-of-range queries and half_order 0 skip the node walk. The hand-off stalls
// while the output register still holds a result that the out side has not taken.
// Reset restores the registers; both memories are undefined until written.
module kernel_upsample_2d #(
    parameter int KERN_SIDE       = 33,
    parameter int MAX_COARSE_SIDE = 64,
    parameter int SAMPLE_BITS     = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  kup_pkg::in_item_t     in_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output kup_pkg::out_item_t    out_item,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [3:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int KQ_DEPTH = KERN_SIDE * KERN_SIDE;
    localparam int CS_DEPTH = MAX_COARSE_SIDE * MAX_COARSE_SIDE;
    localparam int KA_BITS  = $clog2(KQ_DEPTH);
    localparam int KS_BITS  = $clog2(KERN_SIDE + 1);
    localparam int CA_BITS  = $clog2(CS_DEPTH);
    localparam int CS_BITS  = $clog2(MAX_COARSE_SIDE);
    localparam int CW_BITS  = $clog2(MAX_COARSE_SIDE + 1);
    localparam int PROD_BITS = 16 + SAMPLE_BITS;
    localparam int SUM_BITS  = PROD_BITS + 8;

    // configuration registers
    logic [6:0] width_reg, height_reg;
    logic [3:0] factor_reg;
    logic [2:0] order_reg;
    logic       cfg_wr;
    logic [1:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 7'd16;
            height_reg <= 7'd16;
            factor_reg <= 4'd4;
            order_reg  <= 3'd2;
        end
        else if (cfg_wr)
        begin
            unique case (kup_pkg::reg_idx_t'(cfg_idx))
                kup_pkg::REG_WIDTH:  width_reg  <= pwdata[6:0];
                kup_pkg::REG_HEIGHT: height_reg <= pwdata[6:0];
                kup_pkg::REG_FACTOR: factor_reg <= pwdata[3:0];
                kup_pkg::REG_ORDER:  order_reg  <= pwdata[2:0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        unique case (kup_pkg::reg_idx_t'(cfg_idx))
            kup_pkg::REG_WIDTH:  prdata = {25'd0, width_reg};
            kup_pkg::REG_HEIGHT: prdata = {25'd0, height_reg};
            kup_pkg::REG_FACTOR: prdata = {28'd0, factor_reg};
            kup_pkg::REG_ORDER:  prdata = {29'd0, order_reg};
            default:             prdata = 32'd0;
        endcase
    end

    // effective configuration
    logic [3:0]         f_eff;
    logic [CW_BITS-1:0] w_eff, h_eff;
    assign f_eff = (factor_reg == 4'd0) ? 4'd1 : factor_reg;
    assign w_eff = (32'(width_reg) > MAX_COARSE_SIDE) ? CW_BITS'(MAX_COARSE_SIDE)
                                                      : CW_BITS'(width_reg);
    assign h_eff = (32'(height_reg) > MAX_COARSE_SIDE) ? CW_BITS'(MAX_COARSE_SIDE)
                                                       : CW_BITS'(height_reg);

    // memories
    logic signed [15:0]            kq_mem [KQ_DEPTH];
    logic signed [SAMPLE_BITS-1:0] cs_mem [CS_DEPTH];
    logic signed [15:0]            kq_rd_reg;
    logic signed [SAMPLE_BITS-1:0] cs_rd_reg;
    logic [KA_BITS-1:0]            kq_raddr;
    logic [CA_BITS-1:0]            cs_raddr;
    logic                          kq_we, cs_we;
    logic [KA_BITS-1:0]            kq_waddr;
    logic [CA_BITS-1:0]            cs_waddr;

    always_ff @(posedge clk)
    begin
        if (kq_we)
            kq_mem[kq_waddr] <= in_item.load_value;
        kq_rd_reg <= kq_mem[kq_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cs_we)
            cs_mem[cs_waddr] <= SAMPLE_BITS'(in_item.load_value);
        cs_rd_reg <= cs_mem[cs_raddr];
    end

    // sequencer registers
    kup_pkg::state_t state_reg, state_next;
    logic                      accept;
    logic [3:0]                div_cnt_reg;
    logic [8:0]                qx_reg, qy_reg;      // quotient (cell)
    logic [3:0]                rx_reg, ry_reg;      // remainder (offset)
    logic [3:0]                nx_reg, ny_reg;      // node counters 0..2*ho-1
    logic                      last_node;
    logic                      node_ok_reg;
    logic signed [PROD_BITS-1:0] prod_reg;
    logic signed [SUM_BITS-1:0]  sum_reg;
    logic                      rerr_reg;
    kup_pkg::out_item_t        res_word;
    logic                      out_valid_reg;
    kup_pkg::out_item_t        out_item_reg;
    logic                      out_free;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == kup_pkg::ST_IDLE);
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // load writes
    always_comb
    begin
        kq_we    = accept && (in_item.operation == kup_pkg::OP_LOAD_KERNEL)
                   && (32'(in_item.kern_col) < KERN_SIDE)
                   && (32'(in_item.kern_row) < KERN_SIDE);
        cs_we    = accept && (in_item.operation == kup_pkg::OP_LOAD_SAMPLE)
                   && (32'(in_item.coarse_col) < MAX_COARSE_SIDE)
                   && (32'(in_item.coarse_row) < MAX_COARSE_SIDE);
        kq_waddr = KA_BITS'(32'(in_item.kern_row) * KERN_SIDE + 32'(in_item.kern_col));
        cs_waddr = CA_BITS'(32'(in_item.coarse_row) * MAX_COARSE_SIDE
                   + 32'(in_item.coarse_col));
    end

    // node step decode: first ho steps lower side (step s), rest upper (s-ho+1)
    logic [3:0]         sx, sy;
    logic               upx, upy;
    logic signed [10:0] cellx, celly;
    logic signed [7:0]  kix, kiy;
    logic               ok_now;
    always_comb
    begin
        upx = (nx_reg >= {1'b0, order_reg});
        upy = (ny_reg >= {1'b0, order_reg});
        sx  = upx ? (nx_reg - {1'b0, order_reg} + 4'd1) : nx_reg;
        sy  = upy ? (ny_reg - {1'b0, order_reg} + 4'd1) : ny_reg;
        cellx = upx ? $signed({2'b0, qx_reg}) + $signed({7'b0, sx})
                    : $signed({2'b0, qx_reg}) - $signed({7'b0, sx});
        celly = upy ? $signed({2'b0, qy_reg}) + $signed({7'b0, sy})
                    : $signed({2'b0, qy_reg}) - $signed({7'b0, sy});
        kix = upx ? $signed(8'(sx * f_eff)) - $signed({4'b0, rx_reg})
                  : $signed(8'(sx * f_eff)) + $signed({4'b0, rx_reg});
        kiy = upy ? $signed(8'(sy * f_eff)) - $signed({4'b0, ry_reg})
                  : $signed(8'(sy * f_eff)) + $signed({4'b0, ry_reg});
        ok_now = (cellx >= 0) && (celly >= 0)
                 && (cellx < $signed({1'b0, 10'(w_eff)}))
                 && (celly < $signed({1'b0, 10'(h_eff)}))
                 && (kix >= 0) && (kiy >= 0)
                 && (kix < 8'(KERN_SIDE)) && (kiy < 8'(KERN_SIDE));
        kq_raddr = KA_BITS'(32'($unsigned(KS_BITS'(kiy))) * KERN_SIDE
                   + 32'($unsigned(KS_BITS'(kix))));
        cs_raddr = CA_BITS'(32'($unsigned(CS_BITS'(celly))) * MAX_COARSE_SIDE
                   + 32'($unsigned(CS_BITS'(cellx))));
        last_node = (nx_reg == {order_reg, 1'b0} - 4'd1)
                    && (ny_reg == {order_reg, 1'b0} - 4'd1);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            kup_pkg::ST_IDLE:
                if (accept && in_item.operation == kup_pkg::OP_QUERY)
                    state_next = kup_pkg::ST_DIV;
            kup_pkg::ST_DIV:
                if (div_cnt_reg == 4'd0)
                    state_next = kup_pkg::ST_SETUP;
            kup_pkg::ST_SETUP:
                if (rerr_reg || order_reg == 3'd0)
                    state_next = kup_pkg::ST_DONE;
                else
                    state_next = kup_pkg::ST_READ;
            kup_pkg::ST_READ:  state_next = kup_pkg::ST_MUL;
            kup_pkg::ST_MUL:   state_next = kup_pkg::ST_ACC;
            kup_pkg::ST_ACC:
                state_next = last_node ? kup_pkg::ST_DONE : kup_pkg::ST_READ;
            kup_pkg::ST_DONE:
                if (out_free)
                    state_next = kup_pkg::ST_IDLE;
            default: state_next = kup_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= kup_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // datapath: divider, node walk, multiply, accumulate
    logic [4:0]  trx, try_;
    logic [11:0] lim_x, lim_y;
    logic signed [SUM_BITS-1:0] shifted;
    assign trx  = {rx_reg, qx_reg[8]} - {1'b0, f_eff};
    assign try_ = {ry_reg, qy_reg[8]} - {1'b0, f_eff};
    assign lim_x = 12'(f_eff) * 12'(w_eff);
    assign lim_y = 12'(f_eff) * 12'(h_eff);
    assign shifted = sum_reg >>> 14;

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            kup_pkg::ST_IDLE:
            begin
                qx_reg      <= in_item.fine_col;
                qy_reg      <= in_item.fine_row;
                rx_reg      <= 4'd0;
                ry_reg      <= 4'd0;
                div_cnt_reg <= 4'd8;
                rerr_reg    <= (12'(in_item.fine_col) >= lim_x)
                               || (12'(in_item.fine_row) >= lim_y);
                nx_reg      <= 4'd0;
                ny_reg      <= 4'd0;
                sum_reg     <= '0;
            end
            kup_pkg::ST_DIV:
            begin
                // restoring division, one quotient bit per cycle
                if (!trx[4])
                begin
                    rx_reg <= trx[3:0];
                    qx_reg <= {qx_reg[7:0], 1'b1};
                end
                else
                begin
                    rx_reg <= {rx_reg[2:0], qx_reg[8]};
                    qx_reg <= {qx_reg[7:0], 1'b0};
                end
                if (!try_[4])
                begin
                    ry_reg <= try_[3:0];
                    qy_reg <= {qy_reg[7:0], 1'b1};
                end
                else
                begin
                    ry_reg <= {ry_reg[2:0], qy_reg[8]};
                    qy_reg <= {qy_reg[7:0], 1'b0};
                end
                div_cnt_reg <= div_cnt_reg - 4'd1;
            end
            kup_pkg::ST_READ:
                node_ok_reg <= ok_now;
            kup_pkg::ST_MUL:
                prod_reg <= node_ok_reg ? PROD_BITS'(kq_rd_reg * cs_rd_reg) : '0;
            kup_pkg::ST_ACC:
            begin
                sum_reg <= sum_reg + SUM_BITS'(prod_reg);
                if (ny_reg == {order_reg, 1'b0} - 4'd1)
                begin
                    ny_reg <= 4'd0;
                    nx_reg <= nx_reg + 4'd1;
                end
                else
                    ny_reg <= ny_reg + 4'd1;
            end
            default: ;
        endcase
    end

    // result: flag out-of-range queries, saturate the shifted sum
    always_comb
    begin
        if (rerr_reg)
        begin
            res_word.interpolated_value = '0;
            res_word.range_error        = 1'b1;
        end
        else
        begin
            res_word.range_error = 1'b0;
            if (shifted > SUM_BITS'((1 << (kup_pkg::OUT_BITS - 1)) - 1))
                res_word.interpolated_value = {1'b0, {(kup_pkg::OUT_BITS-1){1'b1}}};
            else if (shifted < -SUM_BITS'(1 << (kup_pkg::OUT_BITS - 1)))
                res_word.interpolated_value = {1'b1, {(kup_pkg::OUT_BITS-1){1'b0}}};
            else
                res_word.interpolated_value = shifted[kup_pkg::OUT_BITS-1:0];
        end
    end

    // output register: load a finished query when free, drop it once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_item_reg  <= '0;
        end
        else if (state_reg == kup_pkg::ST_DONE && out_free)
        begin
            out_valid_reg <= 1'b1;
            out_item_reg  <= res_word;
        end
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

`ifndef NO_ASSERTIONS
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != kup_pkg::ST_IDLE) |-> !in_ready) else $error("ready while busy");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_item)))
        else $error("result dropped or changed");
    a_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == kup_pkg::ST_SETUP) |-> (rx_reg < f_eff && ry_reg < f_eff))
        else $error("remainder not below factor");
`endif

endmodule
